>>> hw/rtl/scrolling_sea_sky_line_renderer_assert.svh
// ----------------------------------------------------------------------------
// scrolling_sea_sky_line_renderer_assert.svh
// assertion macros used by the renderer top module
// ----------------------------------------------------------------------------
`ifndef SCROLLING_SEA_SKY_LINE_RENDERER_ASSERT_SVH
`define SCROLLING_SEA_SKY_LINE_RENDERER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sslr_pkg.sv
// ----------------------------------------------------------------------------
// sslr_pkg
// types, codes and constant tables of the sea and sky line renderer
// ----------------------------------------------------------------------------
package sslr_pkg;

    // request function codes
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_LINE  = 2'd1;
    localparam logic [1:0] FUNC_FRAME = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FLIP_MODE = 2'd0;
    localparam logic [1:0] CFG_SUN_LEVEL = 2'd1;
    localparam logic [1:0] CFG_SEA_LEVEL = 2'd2;

    localparam int LINE_PIXELS      = 256;
    localparam int STAR_TABLE_DEPTH = 63;
    localparam int STAR_ROWS        = 32;

    localparam logic [7:0]  HORIZON_BASE = 8'd120;
    localparam logic [10:0] SEA_BASE     = 11'h008;
    localparam logic [10:0] SKY_BASE     = 11'h208;
    localparam logic [10:0] STAR_ADD     = 11'h100;
    localparam logic [8:0]  LINE_MAX     = 9'd256;
    localparam logic [8:0]  SCROLL_LINE  = 9'd128;

    // configuration registers
    typedef struct packed {
        logic       flip_mode;
        logic [7:0] sun_level;
        logic [7:0] sea_level;
    } t_cfg;

    // counter commands
    typedef struct packed {
        logic step;
        logic commit;
    } t_cnt_ctrl;

    // horizon wave offset by line mod 8
    typedef logic [7:0][1:0] t_wave;
    localparam t_wave WAVE_TAB = {2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0};

    // star x offset for each group of eight lines
    typedef logic [STAR_ROWS-1:0][6:0] t_star_rom;

    // walks the shift sequence, then picks entry (5 * (8k + 4)) mod 63 per row
    function automatic t_star_rom star_rom_build();
        logic [7:0] d;
        logic       b;
        logic [3:0] tab [STAR_TABLE_DEPTH];
        logic [6:0] idx;
        logic [3:0] e;
        t_star_rom  rom;
        d   = 8'd0;
        rom = '0;
        for (int i = 0; i < STAR_TABLE_DEPTH; i++) begin
            b      = d[6] ^ d[7] ^ 1'b1;
            d      = {d[6:0], b};
            tab[i] = d[3:0];
        end
        idx = 7'd20;
        for (int k = 0; k < STAR_ROWS; k++) begin
            e      = tab[idx[5:0]];
            rom[k] = {e[0], e[1], e[2], e[3], 3'b000};
            idx    = idx + 7'd40;
            if (idx >= 7'd63) begin
                idx = idx - 7'd63;
            end
        end
        return rom;
    endfunction

    localparam t_star_rom STAR_ROM = star_rom_build();

endpackage

>>> hw/rtl/scrolling_sea_sky_line_renderer.sv
// ----------------------------------------------------------------------------
// scrolling_sea_sky_line_renderer
// per-pixel palette index for a scrolling sea and sky line
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_func, i_pixel_x, i_video_byte,
//                                             i_color_byte
//   result    out        o_valid / i_stall    o_palette_index
//   config    in         i_cfg_we             i_cfg_addr, i_cfg_wdata
//
// one request per clock while o_stall is low; an accepted pixel request passes
// through the input register, shade logic and result register. line and frame requests
// update the counters when they leave the input register and give no result.
// reset is synchronous active low and clears counters, config and valids.
// a stalled result holds; the input register keeps filling behind it and
// o_stall rises only when a pixel request cannot move into the result register.
// ----------------------------------------------------------------------------
module scrolling_sea_sky_line_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_video_byte,
    input  logic [7:0]  i_color_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_palette_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);
    import sslr_pkg::*;

    `include "scrolling_sea_sky_line_renderer_assert.svh"

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [7:0]  r_pixel_x;
    logic [7:0]  r_video_byte;
    logic [7:0]  r_color_byte;
    logic        r_out_valid;
    logic [10:0] r_palette_index;
    logic        w_out_free;
    logic        w_fire;
    logic        w_is_pixel;
    t_cnt_ctrl   w_ctrl;
    logic [8:0]  w_work_line;
    logic [8:0]  w_base_line;
    logic [1:0]  w_base_scroll;
    logic [10:0] w_pix;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FLIP_MODE: r_cfg.flip_mode <= i_cfg_wdata[0];
                CFG_SUN_LEVEL: r_cfg.sun_level <= i_cfg_wdata;
                CFG_SEA_LEVEL: r_cfg.sea_level <= i_cfg_wdata;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // input register moves on unless a pixel is blocked by a held result
    assign w_is_pixel  = r_func == FUNC_PIXEL;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_fire      = r_in_valid && (!w_is_pixel || w_out_free);
    assign o_stall     = r_in_valid && !w_fire;
    assign w_ctrl.step   = w_fire && (r_func == FUNC_LINE);
    assign w_ctrl.commit = w_fire && (r_func == FUNC_FRAME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_func       <= i_func;
            r_pixel_x    <= i_pixel_x;
            r_video_byte <= i_video_byte;
            r_color_byte <= i_color_byte;
        end
    end

    // line and frame counters
    sslr_counters u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_flip_mode   (r_cfg.flip_mode),
        .o_work_line   (w_work_line),
        .o_base_line   (w_base_line),
        .o_base_scroll (w_base_scroll)
    );

    // pixel shading
    sslr_shade u_shade (
        .i_cfg           (r_cfg),
        .i_work_line     (w_work_line),
        .i_pixel_x       (r_pixel_x),
        .i_video_byte    (r_video_byte),
        .i_color_byte    (r_color_byte),
        .o_palette_index (w_pix)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_pixel) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_pixel) begin
            r_palette_index <= w_pix;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_palette_index = r_palette_index;

    // checks
    `SSLR_ASSERT_NOW(a_line_range, i_clk, i_rst_n, 1'b1, w_work_line <= LINE_MAX, "line counter out of range")
    `SSLR_ASSERT_NEXT(a_pixel_result, i_clk, i_rst_n, w_fire && w_is_pixel, r_out_valid, "pixel request gave no result")
    `SSLR_ASSERT_NEXT(a_line_hold, i_clk, i_rst_n, !w_ctrl.step, $stable(w_work_line), "line counter moved without a line request")
    `SSLR_ASSERT_NEXT(a_base_hold, i_clk, i_rst_n, !w_ctrl.commit, $stable({w_base_scroll, w_base_line}), "frame base moved")

endmodule

>>> hw/rtl/sslr_counters.sv
// ----------------------------------------------------------------------------
// sslr_counters
// line and scroll counters with frame base commit
// ----------------------------------------------------------------------------
module sslr_counters (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sslr_pkg::t_cnt_ctrl i_ctrl,
    input  logic               i_flip_mode,
    output logic [8:0]         o_work_line,
    output logic [8:0]         o_base_line,
    output logic [1:0]         o_base_scroll
);
    import sslr_pkg::*;

    logic [8:0] r_work_line, n_work_line;
    logic [1:0] r_work_scroll, n_work_scroll;
    logic [8:0] r_base_line;
    logic [1:0] r_base_scroll;
    logic [9:0] w_inc;

    // next line with wrap modulus picked by scroll phase and flip
    always_comb begin
        w_inc         = {1'b0, r_work_line} + 10'd1;
        n_work_line   = r_work_line;
        n_work_scroll = r_work_scroll;
        if (i_ctrl.step) begin
            if (r_work_scroll == 2'd2) begin
                n_work_line = {1'b0, w_inc[7:0]};
            end else if (i_flip_mode) begin
                n_work_line = (w_inc >= 10'd255) ? 9'(w_inc - 10'd255) : w_inc[8:0];
            end else begin
                n_work_line = (w_inc >= 10'd257) ? 9'(w_inc - 10'd257) : w_inc[8:0];
            end
            if (n_work_line == SCROLL_LINE) begin
                n_work_scroll = r_work_scroll + 2'd1;
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_line   <= '0;
            r_work_scroll <= '0;
            r_base_line   <= '0;
            r_base_scroll <= '0;
        end else begin
            r_work_line   <= n_work_line;
            r_work_scroll <= n_work_scroll;
            if (i_ctrl.commit) begin
                r_base_line   <= r_work_line;
                r_base_scroll <= r_work_scroll;
            end
        end
    end

    assign o_work_line   = r_work_line;
    assign o_base_line   = r_base_line;
    assign o_base_scroll = r_base_scroll;

endmodule

>>> hw/rtl/sslr_shade.sv
// ----------------------------------------------------------------------------
// sslr_shade
// palette index of one pixel: sea, sky, star and foreground
// ----------------------------------------------------------------------------
module sslr_shade (
    input  sslr_pkg::t_cfg i_cfg,
    input  logic [8:0]     i_work_line,
    input  logic [7:0]     i_pixel_x,
    input  logic [7:0]     i_video_byte,
    input  logic [7:0]     i_color_byte,
    output logic [10:0]    o_palette_index
);
    import sslr_pkg::*;

    logic [7:0]  w_horizon;
    logic        w_sky;
    logic [8:0]  w_sky_sum;
    logic [8:0]  w_sea_sum;
    logic [7:0]  w_shade;
    logic [6:0]  w_star_d;
    logic        w_star_up;
    logic        w_star_lo;
    logic [7:0]  w_star_x;
    logic        w_star_hit;
    logic [2:0]  w_bit_sel;
    logic [10:0] w_bg;

    // horizon and saturated shades
    assign w_horizon = HORIZON_BASE + {6'd0, WAVE_TAB[i_work_line[2:0]]};
    assign w_sky     = i_pixel_x >= w_horizon;
    assign w_sky_sum = {1'b0, i_cfg.sun_level} + {1'b0, 8'(i_pixel_x - w_horizon)};
    assign w_sea_sum = {1'b0, i_cfg.sea_level} + {1'b0, i_pixel_x};
    always_comb begin
        if (w_sky) begin
            w_shade = w_sky_sum[8] ? 8'hff : w_sky_sum[7:0];
        end else begin
            w_shade = w_sea_sum[8] ? 8'hff : w_sea_sum[7:0];
        end
    end

    // star rows: upper on line mod 8 of 4, lower on 5
    assign w_star_d   = STAR_ROM[i_work_line[7:3]];
    assign w_star_up  = i_work_line[2:0] == 3'd4;
    assign w_star_lo  = i_work_line[2:0] == 3'd5;
    assign w_star_x   = {w_star_up, w_star_d};
    assign w_star_hit = (w_star_up || w_star_lo) && (w_star_x == i_pixel_x);

    // background, stars only show in the sky
    always_comb begin
        if (w_sky) begin
            w_bg = SKY_BASE + {3'd0, w_shade} + (w_star_hit ? STAR_ADD : 11'd0);
        end else begin
            w_bg = SEA_BASE + {3'd0, w_shade};
        end
    end

    // foreground bit overrides, order reversed in flip mode
    assign w_bit_sel = i_cfg.flip_mode ? ~i_pixel_x[2:0] : i_pixel_x[2:0];
    assign o_palette_index = i_video_byte[w_bit_sel] ? {8'd0, i_color_byte[2:0]} : w_bg;

endmodule

>>> verif/scrolling_sea_sky_line_renderer_test.sv
// ----------------------------------------------------------------------------
// scrolling_sea_sky_line_renderer_test
// self-checking bench for the sea and sky line renderer
//
// drives pixel, line and frame requests through the valid/stall handshake.
// a scoreboard class keeps its own line and scroll counters, the star table
// and the register values, and predicts each palette index. results are
// compared in order against that prediction. the run sweeps several register
// settings and idle patterns, including a long result hold-off that backs up
// the request side.
// ----------------------------------------------------------------------------
module scrolling_sea_sky_line_renderer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sslr_pkg::*;

    // func code the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 2000;

    // ------------------------------------------------------------------------
    // palette scoreboard: predicts each pixel and holds the pending indexes
    // ------------------------------------------------------------------------
    class palette_checker;
        localparam int HORIZON_START = 120;
        localparam int SEA_OFFSET = 'h8;
        localparam int SKY_OFFSET = 'h208;
        localparam int STAR_BRIGHT = 'h100;
        localparam int SHADE_TOP = 255;
        localparam int STAR_STRIDE = 320;

        logic        flip;
        logic [7:0]  sun;
        logic [7:0]  sea;
        logic [8:0]  line_cnt;
        logic [1:0]  scroll_cnt;
        logic [8:0]  frame_line;
        logic [1:0]  frame_scroll;
        logic [3:0]  star_entry [63];
        int          wave_ofs [8];
        logic [10:0] expected_palette [$];
        int          errors;
        int          pixels;
        int          lines;
        int          frames;
        int          star_hits;
        int          fg_hits;
        bit [3:0]    scroll_seen;

        function new();
            logic [7:0] sr;
            sr = 8'd0;
            // star positions come from an 8-bit shift sequence seeded at zero
            for (int i = 0; i < 63; i++) begin
                sr = {sr[6:0], sr[6] ^ sr[7] ^ 1'b1};
                star_entry[i] = sr[3:0];
            end
            wave_ofs = '{0, 1, 2, 2, 2, 1, 0, 0};
            flip = 1'b0;
            sun = 8'd0;
            sea = 8'd0;
            line_cnt = 9'd0;
            scroll_cnt = 2'd0;
            frame_line = 9'd0;
            frame_scroll = 2'd0;
            errors = 0;
            pixels = 0;
            lines = 0;
            frames = 0;
            star_hits = 0;
            fg_hits = 0;
            scroll_seen = 4'b0001;
        endfunction

        function void set_register(logic [1:0] addr, logic [7:0] data);
            case (addr)
                CFG_FLIP_MODE: flip = data[0];
                CFG_SUN_LEVEL: sun = data;
                CFG_SEA_LEVEL: sea = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_palette.size();
        endfunction

        // star column on the current line, -1 when the line has none
        function int star_column();
            int         idx;
            logic [3:0] e;
            logic [6:0] ofs;
            if (line_cnt[2:0] == 3'd4) begin
                idx = (STAR_STRIDE * int'(line_cnt)) % 63;
            end else if (line_cnt[2:0] == 3'd5) begin
                idx = (STAR_STRIDE * (int'(line_cnt) - 1)) % 63;
            end else begin
                return -1;
            end
            e = star_entry[idx];
            ofs = {e[0], e[1], e[2], e[3], 3'b000};
            return (line_cnt[2:0] == 3'd4) ? 128 + int'(ofs) : int'(ofs);
        endfunction

        function logic [10:0] predict_palette(logic [7:0] x, logic [7:0] v, logic [7:0] c);
            int   horizon;
            int   shade;
            int   pix;
            int   star;
            logic fg;
            horizon = HORIZON_START + wave_ofs[line_cnt[2:0]];
            star = star_column();
            fg = flip ? v[7 - x[2:0]] : v[x[2:0]];
            // sky at or right of the horizon, sea to the left
            if (int'(x) >= horizon) begin
                shade = int'(sun) + int'(x) - horizon;
                if (shade > SHADE_TOP) shade = SHADE_TOP;
                pix = SKY_OFFSET + shade;
                if (star == int'(x)) begin
                    pix = pix + STAR_BRIGHT;
                    if (!fg) star_hits++;
                end
            end else begin
                shade = int'(sea) + int'(x);
                if (shade > SHADE_TOP) shade = SHADE_TOP;
                pix = SEA_OFFSET + shade;
            end
            // foreground wins over everything
            if (fg) begin
                pix = int'(c[2:0]);
                fg_hits++;
            end
            return 11'(pix);
        endfunction

        function void step_line();
            int m;
            m = int'(line_cnt) + 1;
            if (scroll_cnt == 2'd2) m = m % 256;
            else if (flip) m = m % 255;
            else m = m % 257;
            line_cnt = 9'(m);
            if (line_cnt == 9'd128) scroll_cnt = scroll_cnt + 2'd1;
            scroll_seen[scroll_cnt] = 1'b1;
        endfunction

        function void note_request(logic [1:0] f, logic [7:0] x, logic [7:0] v,
                                   logic [7:0] c);
            case (f)
                FUNC_PIXEL: begin
                    expected_palette.push_back(predict_palette(x, v, c));
                    pixels++;
                end
                FUNC_LINE: begin
                    step_line();
                    lines++;
                end
                FUNC_FRAME: begin
                    frame_line = line_cnt;
                    frame_scroll = scroll_cnt;
                    frames++;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_palette(logic [10:0] got);
            logic [10:0] want;
            if (expected_palette.size() == 0) begin
                report($sformatf("palette_index %0h with no pixel pending", got));
            end else begin
                want = expected_palette.pop_front();
                if (got !== want)
                    report($sformatf("palette_index %0h, wanted %0h", got, want));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = FUNC_PIXEL;
    logic [7:0]  i_pixel_x = 8'd0;
    logic [7:0]  i_video_byte = 8'd0;
    logic [7:0]  i_color_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [10:0] o_palette_index;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = CFG_FLIP_MODE;
    logic [7:0]  i_cfg_wdata = 8'd0;

    palette_checker sb = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int requests_sent = 0;

    always #5 i_clk = ~i_clk;

    scrolling_sea_sky_line_renderer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_pixel_x       (i_pixel_x),
        .i_video_byte    (i_video_byte),
        .i_color_byte    (i_color_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_palette_index (o_palette_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // result side stall: random, or a long hold when one is asked for
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_palette(o_palette_index);
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck = 0;
            else stuck++;
        end
        $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
        $display("scrolling_sea_sky_line_renderer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------------
    task automatic send_request(logic [1:0] f, logic [7:0] x, logic [7:0] v, logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_pixel_x <= x;
        i_video_byte <= v;
        i_color_byte <= c;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(f, x, v, c);
        if (f != FUNC_UNUSED) requests_sent++;
    endtask

    // stop sending until every pixel result is back and the pipe is quiet
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic flip, logic [7:0] sun, logic [7:0] sea);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_FLIP_MODE;
        i_cfg_wdata <= {7'd0, flip};
        @(posedge i_clk);
        sb.set_register(CFG_FLIP_MODE, {7'd0, flip});
        i_cfg_addr <= CFG_SUN_LEVEL;
        i_cfg_wdata <= sun;
        @(posedge i_clk);
        sb.set_register(CFG_SUN_LEVEL, sun);
        i_cfg_addr <= CFG_SEA_LEVEL;
        i_cfg_wdata <= sea;
        @(posedge i_clk);
        sb.set_register(CFG_SEA_LEVEL, sea);
        i_cfg_we <= 1'b0;
    endtask

    // pixel biased toward the horizon and the star column
    task automatic random_pixel();
        int         star;
        logic [7:0] x;
        logic [7:0] v;
        star = sb.star_column();
        case ($urandom_range(7))
            0, 1: x = 8'($urandom_range(112, 135));
            2: x = (star >= 0) ? 8'(star) : 8'($urandom_range(255));
            default: x = 8'($urandom_range(255));
        endcase
        case ($urandom_range(3))
            0, 1: v = 8'd0;
            2: v = 8'd1 << $urandom_range(7);
            default: v = 8'($urandom_range(255));
        endcase
        send_request(FUNC_PIXEL, x, v, 8'($urandom_range(255)));
    endtask

    // a few pixels then end of line, sometimes a frame or an ignored code
    task automatic random_line();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
        repeat (n) random_pixel();
        send_request(FUNC_LINE, 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(39) == 0)
            send_request(FUNC_FRAME, 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(29) == 0)
            send_request(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_lines(int budget);
        int target;
        target = requests_sent + budget;
        while (requests_sent < target) random_line();
    endtask

    task automatic run_phase(logic flip, logic [7:0] sun, logic [7:0] sea,
                             int tx_pct, int rx_pct, int budget);
        write_config(flip, sun, sea);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        run_lines(budget);
    endtask

    // edges of the fields, foreground both ways, stars and the ignored code
    task automatic directed_requests();
        int star;
        write_config(1'b0, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd255, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd119, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd120, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd7, 8'h80, 8'hff);
        send_request(FUNC_PIXEL, 8'd0, 8'h01, 8'h05);
        send_request(FUNC_PIXEL, 8'd3, 8'hf7, 8'hff);
        send_request(FUNC_UNUSED, 8'hff, 8'hff, 8'hff);
        send_request(FUNC_FRAME, 8'd0, 8'd0, 8'd0);
        repeat (4) send_request(FUNC_LINE, 8'd0, 8'd0, 8'd0);
        // upper star row: plain, under foreground, and its neighbor
        star = sb.star_column();
        send_request(FUNC_PIXEL, 8'(star), 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'(star), 8'hff, 8'h02);
        send_request(FUNC_PIXEL, 8'(star + 1), 8'd0, 8'd0);
        // lower star row lands in the sea
        send_request(FUNC_LINE, 8'd0, 8'd0, 8'd0);
        star = sb.star_column();
        send_request(FUNC_PIXEL, 8'(star), 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd121, 8'd0, 8'd0);
        send_request(FUNC_FRAME, 8'd0, 8'd0, 8'd0);
        // flipped bit order and saturated shades
        write_config(1'b1, 8'd255, 8'd255);
        send_request(FUNC_PIXEL, 8'd0, 8'h80, 8'h03);
        send_request(FUNC_PIXEL, 8'd0, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd255, 8'd0, 8'd0);
        send_request(FUNC_PIXEL, 8'd130, 8'h01, 8'h06);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_requests();
        run_phase(1'b0, 8'd0, 8'd0, 0, 0, 200);
        run_phase(1'b1, 8'd255, 8'd255, 50, 0, 200);
        // long hold-off on results fills the block and stalls requests
        run_phase(1'b0, 8'd255, 8'd0, 0, 50, 0);
        hold_req <= hold_req + 1;
        run_lines(200);
        run_phase(1'b1, 8'd0, 8'd255, 9, 9, 200);
        run_phase(1'b0, 8'($urandom), 8'($urandom), 0, 0, 100);
        drain();
        run_lines(100);
        run_phase(1'b1, 8'($urandom), 8'($urandom), 9, 9, 200);

        // let the last results come back
        drain();
        if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
        $display("covered %0d pixel, %0d line and %0d frame requests; scroll states seen %b",
                 sb.pixels, sb.lines, sb.frames, sb.scroll_seen);
        $display("%0d visible star pixels, %0d foreground pixels, %0d mismatches",
                 sb.star_hits, sb.fg_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("scrolling_sea_sky_line_renderer regression: pass");
        end else begin
            $display("scrolling_sea_sky_line_renderer regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sslr_pkg.sv
hw/rtl/sslr_counters.sv
hw/rtl/sslr_shade.sv
hw/rtl/scrolling_sea_sky_line_renderer.sv
verif/scrolling_sea_sky_line_renderer_test.sv
